// File: hw/rtl/skt_pkg.sv
package skt_pkg;

   // Fixed widths of the transaction fields.
   localparam int KEY_W = 8;
   localparam int TAG_W = 3;

   // Defaults for the top-level parameters.
   localparam int NUM_ENTRIES_DEFAULT = 8;
   localparam int KEY_BITS_DEFAULT    = 8;

endpackage

// File: hw/rtl/skt_req_if.sv
interface skt_req_if;

   logic                      valid;
   logic                      ready;
   logic [skt_pkg::KEY_W-1:0] key;
   logic [skt_pkg::TAG_W-1:0] tag;
   logic                      last_in;

   modport source (output valid, output key, output tag, output last_in, input ready);
   modport sink   (input valid, input key, input tag, input last_in, output ready);

endinterface

// File: hw/rtl/skt_rsp_if.sv
interface skt_rsp_if;

   logic                      valid;
   logic                      ready;
   logic [skt_pkg::KEY_W-1:0] sorted_key;
   logic [skt_pkg::TAG_W-1:0] sorted_tag;
   logic                      last_out;
   logic                      overflow;

   modport source (output valid, output sorted_key, output sorted_tag, output last_out,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_key, input sorted_tag, input last_out,
                   input overflow, output ready);

endinterface

// File: hw/rtl/skt_ram.sv
module skt_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, single read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sort_keys_with_tags.sv
// Channel    Direction  Contents
// req_chan   in         key, tag, last_in      (valid/ready)
// rsp_chan   out        sorted_key, sorted_tag, last_out, overflow (valid/ready)
//
// A transaction into an empty store is written to slot zero, and one arriving at a full
// store is dropped; one into a set already holding entries walks down the memory one entry
// per cycle, moving each stored key greater than the new key up a slot. Emission reads one
// entry at a time, issuing the next read only once the last has reached the output register.
// Reset is synchronous and clears only the control state; every entry is written before it
// is read. Result stalls hold the emission; no input is taken during insertion or emission.
module sort_keys_with_tags #(
   parameter int NUM_ENTRIES = skt_pkg::NUM_ENTRIES_DEFAULT,
   parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   skt_req_if.sink    req_chan,
   skt_rsp_if.source  rsp_chan
);

   // Only the low KEY_BITS bits of the key take part, and the port carries at most
   // KEY_W bits, so the stored key is the narrower of the two.
   localparam int KW = (KEY_BITS < skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W;
   localparam int TW = skt_pkg::TAG_W;
   localparam int EW = KW + TW;
   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int CW = $clog2(NUM_ENTRIES + 1);

   localparam logic [AW-1:0] IDX_ZERO  = '0;
   localparam logic [AW-1:0] IDX_ONE   = AW'(1);
   localparam logic [CW-1:0] CNT_ZERO  = '0;
   localparam logic [CW-1:0] CNT_ONE   = CW'(1);
   localparam logic [CW-1:0] CNT_FULL  = CW'(NUM_ENTRIES);

   // The controller either loads transactions (inserting each into the sorted store),
   // walks an insertion down the store, or emits the sorted set.
   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [AW-1:0]     wpos_ff, wpos_in;
   logic [EW-1:0]     new_ff, new_in;
   logic              set_last_ff, set_last_in;
   logic [AW-1:0]     emit_idx_ff, emit_idx_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_ovf_ff, pend_ovf_in;
   logic              out_valid_ff, out_valid_in;
   logic [skt_pkg::KEY_W-1:0] out_key_ff, out_key_in;
   logic [TW-1:0]     out_tag_ff, out_tag_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [EW-1:0]     ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [EW-1:0]     ram_rdata;

   logic              req_accept;
   logic              store_full;
   logic [EW-1:0]     req_entry;
   logic              greater;
   logic              issue;
   logic              final_issue;

   // The store holds {key, tag} pairs, kept in ascending key order at all times.
   skt_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign store_full     = (count_ff == CNT_FULL);
   assign req_entry      = {req_chan.key[KW-1:0], req_chan.tag};

   // During the walk the read data is the entry just below the target slot. A strictly
   // greater key moves up; an equal key stays below, which keeps ties in load order.
   // At slot zero nothing lies below, so the new entry goes there.
   assign greater = (wpos_ff != IDX_ZERO) && (ram_rdata[EW-1:TW] > new_ff[EW-1:TW]);

   // A read is issued only when the output register is sure to be free by the time the
   // data arrives, so the pending entry always lands without a stall of its own.
   assign issue       = (state_ff == ST_EMIT) && !pend_ff && (!out_valid_ff || rsp_chan.ready);
   assign final_issue = ((CW'(emit_idx_ff) + CNT_ONE) == count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      wpos_in      = wpos_ff;
      new_in       = new_ff;
      set_last_in  = set_last_ff;
      emit_idx_in  = emit_idx_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      pend_ovf_in  = pend_ovf_ff;
      ram_we       = 1'b0;
      ram_waddr    = wpos_ff;
      ram_wdata    = new_ff;
      ram_raddr    = emit_idx_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               set_last_in = req_chan.last_in;
               if (store_full) begin
                  // No room: the transaction is dropped, but its last flag still
                  // closes the set.
                  dropped_in = 1'b1;
                  if (req_chan.last_in) begin
                     state_in = ST_EMIT;
                  end
               end else if (count_ff == CNT_ZERO) begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_ZERO;
                  ram_wdata = req_entry;
                  count_in  = CNT_ONE;
                  if (req_chan.last_in) begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  // Start the walk at the top of the set: target the first free slot
                  // and read the highest stored entry.
                  new_in    = req_entry;
                  wpos_in   = count_ff[AW-1:0];
                  ram_raddr = count_ff[AW-1:0] - IDX_ONE;
                  state_in  = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = wpos_ff;
            if (greater) begin
               ram_wdata = ram_rdata;
               wpos_in   = wpos_ff - IDX_ONE;
               ram_raddr = (wpos_ff - IDX_ONE) - IDX_ONE;
            end else begin
               ram_wdata = new_ff;
               count_in  = count_ff + CNT_ONE;
               state_in  = set_last_ff ? ST_EMIT : ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               ram_raddr    = emit_idx_ff;
               pend_in      = 1'b1;
               pend_last_in = final_issue;
               pend_ovf_in  = dropped_ff;
               emit_idx_in  = emit_idx_ff + IDX_ONE;
               if (final_issue) begin
                  // The set is finished; the last read is still in flight, but its
                  // flags are already captured, so a new set may begin loading.
                  emit_idx_in = IDX_ZERO;
                  count_in    = CNT_ZERO;
                  dropped_in  = 1'b0;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Output register: filled from the pending read, emptied when the sink takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_key_in   = skt_pkg::KEY_W'(ram_rdata[EW-1:TW]);
         out_tag_in   = ram_rdata[TW-1:0];
         out_last_in  = pend_last_ff;
         out_ovf_in   = pend_ovf_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= CNT_ZERO;
         dropped_ff   <= 1'b0;
         emit_idx_ff  <= IDX_ZERO;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         emit_idx_ff  <= emit_idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wpos_ff      <= wpos_in;
      new_ff       <= new_in;
      set_last_ff  <= set_last_in;
      pend_last_ff <= pend_last_in;
      pend_ovf_ff  <= pend_ovf_in;
      out_key_ff   <= out_key_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sorted_key = out_key_ff;
   assign rsp_chan.sorted_tag = out_tag_ff;
   assign rsp_chan.last_out   = out_last_ff;
   assign rsp_chan.overflow   = out_ovf_ff;

`ifndef SYNTH
   // A pending read must never find the output register still occupied.
   a_pend_lands: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !out_valid_ff)
      else $error("pending read found the output register occupied");

   // The fill count never exceeds the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count beyond store depth");

   // Emission only runs on a non-empty set.
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != CNT_ZERO))
      else $error("emission started on an empty set");

   // The insertion target stays within the set being extended.
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ((CW'(wpos_ff) <= count_ff) && !store_full))
      else $error("insertion walk outside the stored set");
`endif

endmodule

// File: tb/sorted_run_board_pkg.sv
`timescale 1ns / 100ps

package sorted_run_board_pkg;

   localparam int               KEY_W    = skt_pkg::KEY_W;
   localparam int               TAG_W    = skt_pkg::TAG_W;
   localparam int               CAPACITY = skt_pkg::NUM_ENTRIES_DEFAULT;
   localparam logic [KEY_W-1:0] KEY_MASK =
      KEY_W'((64'd1 << skt_pkg::KEY_BITS_DEFAULT) - 64'd1);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last_out;
      logic             overflow;
   } sorted_entry_type;

   class sorted_run_board;

      logic [KEY_W-1:0] held_key[CAPACITY];
      logic [TAG_W-1:0] held_tag[CAPACITY];
      int               held_count;
      bit               dropped;
      sorted_entry_type expected_q[$];
      int               mismatches;

      function new();
         held_count = 0;
         dropped    = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Stores one accepted transaction and, when it closes the set, queues the sorted run.
      function void note_request(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, bit last_in);
         logic [KEY_W-1:0] k;
         logic [TAG_W-1:0] t;
         int               i;
         int               j;
         sorted_entry_type entry;
         if (held_count < CAPACITY) begin
            held_key[held_count] = key & KEY_MASK;
            held_tag[held_count] = tag;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!last_in) return;
         // A strict comparison keeps equal keys in the order they were loaded.
         for (i = 1; i < held_count; i++) begin
            k = held_key[i];
            t = held_tag[i];
            j = i;
            while (j > 0 && held_key[j-1] > k) begin
               held_key[j] = held_key[j-1];
               held_tag[j] = held_tag[j-1];
               j--;
            end
            held_key[j] = k;
            held_tag[j] = t;
         end
         for (i = 0; i < held_count; i++) begin
            entry.key      = held_key[i];
            entry.tag      = held_tag[i];
            entry.last_out = (i == held_count - 1);
            entry.overflow = dropped;
            expected_q.push_back(entry);
         end
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      function void check_result(logic [KEY_W-1:0] sorted_key, logic [TAG_W-1:0] sorted_tag,
                                 logic last_out, logic overflow);
         sorted_entry_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: sorted_key %0d sorted_tag %0d", sorted_key, sorted_tag);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (want.key !== sorted_key) begin
            $error("sorted_key: expected %0d, actual %0d", want.key, sorted_key);
            mismatches++;
         end
         if (want.tag !== sorted_tag) begin
            $error("sorted_tag: expected %0d, actual %0d", want.tag, sorted_tag);
            mismatches++;
         end
         if (want.last_out !== last_out) begin
            $error("last_out: expected %0d, actual %0d", want.last_out, last_out);
            mismatches++;
         end
         if (want.overflow !== overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
            mismatches++;
         end
      endfunction

   endclass

endpackage

// File: tb/sort_keys_with_tags_test.sv
`timescale 1ns / 100ps

module sort_keys_with_tags_test;

   localparam int KEY_W    = skt_pkg::KEY_W;
   localparam int TAG_W    = skt_pkg::TAG_W;
   localparam int CAPACITY = sorted_run_board_pkg::CAPACITY;

   // Least number of random input transactions, the point after which neither side idles,
   // and the cycle count at which the run is declared hung.
   localparam int RANDOM_ITEMS = 326;
   localparam int QUIET_FROM   = 270;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;

   logic clock;
   logic reset;

   skt_req_if req_chan ();
   skt_rsp_if rsp_chan ();

   sort_keys_with_tags uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sorted_run_board_pkg::sorted_run_board board;

   // Control shared between the sending and receiving processes.
   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;
   bit hold_request    = 1'b0;
   bit hold_active     = 1'b0;
   int cycles          = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a correct run finishes far inside this limit, so reaching it means
   // the block has hung or results have gone missing.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Result side. Every accepted transaction is handed to the board for checking.
   // Ready is dropped in random bursts, and once for a long stretch on request so
   // that the block fills up and pushes back on its input.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            board.check_result(rsp_chan.sorted_key, rsp_chan.sorted_tag,
                               rsp_chan.last_out, rsp_chan.overflow);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
            hold_active = 1'b0;
            stall_left  = $urandom_range(1, 19) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            hold_active = 1'b0;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offers one transaction and waits for it to be taken. Unless an idle burst follows, valid
   // is left high, so that a following transaction can go out on the very next cycle.
   task automatic send_item(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input bit last_in);
      req_chan.valid   <= 1'b1;
      req_chan.key     <= key;
      req_chan.tag     <= tag;
      req_chan.last_in <= last_in;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(key, tag, last_in);
      // Idle bursts are held back while the receiver is in its long hold, so that
      // the sender keeps pressing against a full block.
      if (sender_idling && !hold_active && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Withdraws valid and waits until every expected result has been received.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Sends one set of the given size. The key pattern chooses between fully random
   // keys, keys crowded into a narrow band so that ties are common, and keys at the
   // two extremes only.
   task automatic send_random_set(input int size, input int pattern, inout int sent);
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] key;
      int               i;
      base = KEY_W'($urandom_range(0, 252));
      for (i = 0; i < size; i++) begin
         case (pattern)
            0: begin
               key = KEY_W'($urandom_range(0, 255));
            end
            1: begin
               key = base + KEY_W'($urandom_range(0, 3));
            end
            default: begin
               key = $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            end
         endcase
         send_item(key, TAG_W'($urandom_range(0, 7)), i == size - 1);
         sent++;
      end
   endtask

   initial begin : stimulus
      int i;
      int sent;
      int set_no;
      int size;
      int pick;
      board = new();
      sent   = 0;
      set_no = 0;
      req_chan.valid   <= 1'b0;
      req_chan.key     <= '0;
      req_chan.tag     <= '0;
      req_chan.last_in <= 1'b0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Single-entry sets at the smallest and largest key and tag.
      send_item(8'h00, 3'd0, 1'b1);
      send_item(8'hFF, 3'd7, 1'b1);
      // A set that fills the store exactly, in descending order, so every insertion after the
      // first walks the whole way down and no entry is dropped.
      for (i = 0; i < CAPACITY; i++) begin
         send_item(KEY_W'(255 - i * 36), TAG_W'(i), i == CAPACITY - 1);
      end
      // Equal keys must come out in load order, with a smaller key among them.
      send_item(8'h80, 3'd1, 1'b0);
      send_item(8'h80, 3'd2, 1'b0);
      send_item(8'h10, 3'd3, 1'b0);
      send_item(8'h80, 3'd4, 1'b1);
      // Overflow: two transactions beyond capacity, the set closed by a dropped one.
      for (i = 0; i < CAPACITY + 2; i++) begin
         send_item(KEY_W'(i * 53 + 7), TAG_W'(i), i == CAPACITY + 1);
      end

      // Random part, set by set. Most sets fit the store; some overflow it.
      while (sent < RANDOM_ITEMS) begin
         if (sent >= QUIET_FROM) begin
            sender_idling   = 1'b0;
            receiver_idling = 1'b0;
         end
         // Long receiver hold while a full set is being loaded and emitted.
         if (set_no == 6) hold_request = 1'b1;
         // Let the block empty completely before carrying on.
         if (set_no == 14) drain_results();
         pick = $urandom_range(0, 9);
         if (set_no == 6) begin
            size = CAPACITY + 3;
         end else if (pick < 7) begin
            size = $urandom_range(1, CAPACITY);
         end else if (pick < 9) begin
            size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
         end else begin
            size = CAPACITY;
         end
         send_random_set(size, $urandom_range(0, 2), sent);
         set_no++;
      end

      // Wait for the last run to come out, then allow a margin for any stray result.
      drain_results();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
